[hw/rtl/assert_macros.svh]
// Assertion macros for the checker file dcm_checker.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under reset.
`define DCM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication under reset.
`define DCM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[hw/rtl/dcm_pkg.sv]
// Types and constants for the difference color mapper.
// No dependencies; imported by dcm_index, dcm_ctab, dcm_color and the top level.
package dcm_pkg;

	localparam int DivSteps = 8;
	localparam logic [7:0] IdxMid = 8'd127;
	localparam logic [7:0] IdxPosMax = 8'd128;

	typedef enum logic [1:0] {
		REG_MODE = 2'd0,
		REG_MAX_SCALE = 2'd1,
		REG_MASK_ENABLE = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_MUL_FIRST = 2'd0,
		MODE_MUL_LAST = 2'd1,
		MODE_ABS_FIRST = 2'd2,
		MODE_ABS_LAST = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		CH_RED = 2'd0,
		CH_GREEN = 2'd1,
		CH_BLUE = 2'd2
	} chan_t;

	typedef struct packed {
		mode_t mode;
		logic [15:0] max_scale;
		logic mask_enable;
	} cfg_t;

	typedef struct packed {
		logic req_type;
		logic [7:0] in_pixel;
		logic [7:0] ref_pixel;
		logic [7:0] mask_pixel;
		logic [7:0] table_index;
		logic [1:0] table_channel;
		logic [7:0] table_value;
	} raw_t;

	typedef struct packed {
		logic tbl;
		logic [7:0] in_px;
		logic [7:0] ref_px;
		logic bypass;
		logic [7:0] mag;
		logic neg;
		logic [7:0] tidx;
		logic [1:0] tch;
		logic [7:0] tval;
	} item_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

endpackage

[hw/rtl/dcm_index.sv]
// Difference, numerator and pipelined restoring division to the table index.
// Depends on dcm_pkg.
module dcm_index (
	input logic clk,
	input logic arst_n,
	input logic en,
	input dcm_pkg::cfg_t cfg,
	input logic vld_i,
	input dcm_pkg::raw_t raw_i,
	output logic vld_o,
	output dcm_pkg::item_t item_o,
	output logic [7:0] idx_o
);
	import dcm_pkg::*;

	logic [15:0] scale;
	logic [16:0] den;
	logic last_mode;
	logic [8:0] diff;
	logic [16:0] shifted;
	logic [16:0] num;
	item_t item_in;

	logic vld_s1;
	item_t item_s1;
	logic [16:0] num_s1;

	logic vld_sd [0:DivSteps];
	item_t item_sd [0:DivSteps];
	logic [16:0] rem_sd [0:DivSteps];
	logic [7:0] quo_sd [0:DivSteps];
	logic sat_sd [0:DivSteps];

	logic [7:0] idx_c;
	logic vld_s11;
	item_t item_s11;
	logic [7:0] idx_s11;

	assign scale = (cfg.max_scale == 16'd0) ? 16'd1 : cfg.max_scale;
	assign den = {scale, 1'b0};
	assign last_mode = (cfg.mode == MODE_MUL_LAST) || (cfg.mode == MODE_ABS_LAST);

	always_comb begin
		diff = last_mode ? ({1'b0, raw_i.ref_pixel} - {1'b0, raw_i.in_pixel})
			: ({1'b0, raw_i.in_pixel} - {1'b0, raw_i.ref_pixel});
		item_in.tbl = raw_i.req_type;
		item_in.in_px = raw_i.in_pixel;
		item_in.ref_px = raw_i.ref_pixel;
		item_in.bypass = cfg.mask_enable && (raw_i.mask_pixel == 8'd0);
		item_in.neg = diff[8];
		item_in.mag = diff[8] ? 8'(-diff) : diff[7:0];
		item_in.tidx = raw_i.table_index;
		item_in.tch = raw_i.table_channel;
		item_in.tval = raw_i.table_value;
		shifted = {1'b0, item_in.mag, 8'h00};
		// negative side: numerator below zero truncates to a zero quotient
		if (item_in.neg) begin
			num = (shifted >= {1'b0, scale}) ? shifted - {1'b0, scale} : 17'd0;
		end else begin
			num = shifted + {1'b0, scale};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= item_in;
			num_s1 <= num;
		end
	end

	// saturation check: quotient of 256 or more clamps anyway
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sd[0] <= 1'b0;
		end else if (en) begin
			vld_sd[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_sd[0] <= item_s1;
			rem_sd[0] <= num_s1;
			quo_sd[0] <= 8'd0;
			sat_sd[0] <= {8'd0, num_s1} >= {den, 8'd0};
		end
	end

	for (genvar j = 0; j < DivSteps; j++) begin : g_div
		localparam int K = DivSteps - 1 - j;
		logic [24:0] dsh;
		logic ge;
		logic [24:0] diff_w;

		always_comb begin
			dsh = {8'd0, den} << K;
			ge = !sat_sd[j] && ({8'd0, rem_sd[j]} >= dsh);
			diff_w = {8'd0, rem_sd[j]} - dsh;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sd[j+1] <= 1'b0;
			end else if (en) begin
				vld_sd[j+1] <= vld_sd[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				item_sd[j+1] <= item_sd[j];
				sat_sd[j+1] <= sat_sd[j];
				rem_sd[j+1] <= ge ? diff_w[16:0] : rem_sd[j];
				quo_sd[j+1] <= sat_sd[j] ? 8'hFF : (quo_sd[j] | (8'(ge) << K));
			end
		end
	end

	always_comb begin
		if (item_sd[DivSteps].neg) begin
			idx_c = (quo_sd[DivSteps] >= IdxMid) ? 8'd0 : IdxMid - quo_sd[DivSteps];
		end else begin
			idx_c = (quo_sd[DivSteps] >= IdxPosMax) ? 8'hFF : quo_sd[DivSteps] + IdxMid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s11 <= 1'b0;
		end else if (en) begin
			vld_s11 <= vld_sd[DivSteps];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s11 <= item_sd[DivSteps];
			idx_s11 <= idx_c;
		end
	end

	assign vld_o = vld_s11;
	assign item_o = item_s11;
	assign idx_o = idx_s11;

endmodule

[hw/rtl/dcm_ctab.sv]
// Color table: one 256-entry bank per channel, written by table words in order.
// Depends on dcm_pkg.
module dcm_ctab (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic vld_i,
	input dcm_pkg::item_t item_i,
	input logic [7:0] idx_i,
	output logic vld_o,
	output dcm_pkg::item_t item_o,
	output dcm_pkg::rgb_t col_o
);
	import dcm_pkg::*;

	logic vld_s12;
	item_t item_s12;
	logic [7:0] rd_s12 [0:2];

	for (genvar c = 0; c < 3; c++) begin : g_bank
		logic [7:0] mem [0:255];

		always_ff @(posedge clk) begin
			if (en && vld_i) begin
				if (item_i.tbl) begin
					if (item_i.tch == 2'(c)) begin
						mem[item_i.tidx] <= item_i.tval;
					end
				end else begin
					rd_s12[c] <= mem[idx_i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s12 <= 1'b0;
		end else if (en) begin
			vld_s12 <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s12 <= item_i;
		end
	end

	assign vld_o = vld_s12;
	assign item_o = item_s12;
	assign col_o = '{r: rd_s12[CH_RED], g: rd_s12[CH_GREEN], b: rd_s12[CH_BLUE]};

endmodule

[hw/rtl/dcm_color.sv]
// Weighting products and final channel selection for one pixel word.
// Depends on dcm_pkg.
module dcm_color (
	input logic clk,
	input logic arst_n,
	input logic en,
	input dcm_pkg::cfg_t cfg,
	input logic vld_i,
	input dcm_pkg::item_t item_i,
	input dcm_pkg::rgb_t col_i,
	output logic push_o,
	output dcm_pkg::rgb_t res_o
);
	import dcm_pkg::*;

	logic vld_s13;
	item_t item_s13;
	rgb_t col_s13;
	logic [15:0] prod_s13 [0:2];
	logic [7:0] tin [0:2];
	logic [7:0] res_c [0:2];
	logic [7:0] base;
	logic absolute;
	logic all_zero;

	assign tin[0] = col_i.r;
	assign tin[1] = col_i.g;
	assign tin[2] = col_i.b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s13 <= 1'b0;
		end else if (en) begin
			vld_s13 <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s13 <= item_i;
			col_s13 <= col_i;
		end
	end

	assign absolute = (cfg.mode == MODE_ABS_FIRST) || (cfg.mode == MODE_ABS_LAST);
	assign base = (cfg.mode == MODE_MUL_FIRST) ? item_s13.ref_px : item_s13.in_px;
	assign all_zero = (col_s13 == '0);

	for (genvar c = 0; c < 3; c++) begin : g_ch
		logic [16:0] y;
		logic [16:0] q;
		logic [7:0] tcol;

		always_ff @(posedge clk) begin
			if (en) begin
				prod_s13[c] <= 16'(item_i.mag * tin[c]);
			end
		end

		assign tcol = (c == 0) ? col_s13.r : ((c == 1) ? col_s13.g : col_s13.b);

		// (2*m*t + 255) / 510 equals (m*t + 127) / 255, done by shift and fold
		always_comb begin
			y = {1'b0, prod_s13[c]} + 17'd127;
			q = (y + 17'd1 + (y >> 8)) >> 8;
			if (item_s13.bypass) begin
				res_c[c] = base;
			end else if (absolute) begin
				res_c[c] = all_zero ? base : tcol;
			end else begin
				res_c[c] = base + q[7:0];
			end
		end
	end

	assign push_o = vld_s13 && !item_s13.tbl;
	assign res_o = '{r: res_c[0], g: res_c[1], b: res_c[2]};

endmodule

[hw/rtl/difference_color_mapper.sv]
// Top level of the difference color mapper: config registers, pipeline, output skid.
// Depends on dcm_pkg, dcm_index, dcm_ctab, dcm_color.
//
//   channel  | handshake            | payload
//   input    | in_valid / in_stall  | req_type .. table_value
//   output   | out_valid / out_stall| red_out, green_out, blue_out
//   config   | cfg_write            | cfg_index, cfg_data
//
// One word enters per cycle while in_stall is low; a pixel result reaches out_valid
// after eight divider stages that build the table index one quotient bit each.
// Table writes flow down the same pipeline and land at the table read stage.
// Reset clears control and config; the color table holds no value until written.
// in_stall rises only while the output word and its skid entry are both full.
module difference_color_mapper (
	input logic clk,
	input logic arst_n,
	input logic cfg_write,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic req_type,
	input logic [7:0] in_pixel,
	input logic [7:0] ref_pixel,
	input logic [7:0] mask_pixel,
	input logic [7:0] table_index,
	input logic [1:0] table_channel,
	input logic [7:0] table_value,
	output logic out_valid,
	input logic out_stall,
	output logic [7:0] red_out,
	output logic [7:0] green_out,
	output logic [7:0] blue_out
);
	import dcm_pkg::*;

	cfg_t cfg_q;
	raw_t raw;
	logic en;
	logic ix_vld;
	item_t ix_item;
	logic [7:0] ix_idx;
	logic tb_vld;
	item_t tb_item;
	rgb_t tb_col;
	logic push;
	rgb_t res;
	logic out_vld_q;
	rgb_t out_q;
	logic skid_vld_q;
	rgb_t skid_q;
	logic pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode <= MODE_MUL_FIRST;
			cfg_q.max_scale <= 16'd128;
			cfg_q.mask_enable <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_MODE: cfg_q.mode <= mode_t'(cfg_data[1:0]);
				REG_MAX_SCALE: cfg_q.max_scale <= cfg_data;
				REG_MASK_ENABLE: cfg_q.mask_enable <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign raw = '{req_type: req_type, in_pixel: in_pixel, ref_pixel: ref_pixel,
		mask_pixel: mask_pixel, table_index: table_index,
		table_channel: table_channel, table_value: table_value};

	// advance the whole pipeline while the skid entry is free
	assign en = !skid_vld_q;
	assign in_stall = skid_vld_q;

	dcm_index u_index (
		.clk(clk), .arst_n(arst_n), .en(en), .cfg(cfg_q),
		.vld_i(in_valid), .raw_i(raw),
		.vld_o(ix_vld), .item_o(ix_item), .idx_o(ix_idx)
	);

	dcm_ctab u_ctab (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_i(ix_vld), .item_i(ix_item), .idx_i(ix_idx),
		.vld_o(tb_vld), .item_o(tb_item), .col_o(tb_col)
	);

	dcm_color u_color (
		.clk(clk), .arst_n(arst_n), .en(en), .cfg(cfg_q),
		.vld_i(tb_vld), .item_i(tb_item), .col_i(tb_col),
		.push_o(push), .res_o(res)
	);

	assign pop = out_vld_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || pop) begin
			if (skid_vld_q) begin
				out_vld_q <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= en && push;
			end
		end else if (en && push) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || pop) begin
			out_q <= skid_vld_q ? skid_q : res;
		end else if (en && push) begin
			skid_q <= res;
		end
	end

	assign out_valid = out_vld_q;
	assign red_out = out_q.r;
	assign green_out = out_q.g;
	assign blue_out = out_q.b;

endmodule

[hw/rtl/dcm_checker.sv]
// Port-level checks for the difference color mapper, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module dcm_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic [7:0] red_out,
	input logic [7:0] green_out,
	input logic [7:0] blue_out
);

	`DCM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`DCM_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable({red_out, green_out, blue_out}))
	`DCM_ASSERT_NOW(a_stall_needs_word, clk, arst_n, in_stall, out_valid)
	`DCM_ASSERT_NOW(a_stall_from_output, clk, arst_n, in_stall, $past(out_valid && out_stall))

endmodule

bind difference_color_mapper dcm_checker u_dcm_checker (.*);

[test/difference_color_mapper_tb.sv]
// Self-checking testbench for difference_color_mapper: loads part of the color table,
// then runs directed and random pixel words under every mode, with random stalls.
// Depends on dcm_pkg and the difference_color_mapper RTL.
`timescale 1ns / 1ps

import dcm_pkg::*;

class dcm_scoreboard;
	logic [7:0] color_lut [0:767];
	bit lut_written [0:767];
	mode_t cur_mode;
	int unsigned cur_scale;
	bit cur_mask_en;
	rgb_t expected_rgb [$];
	int errors;
	int pixel_count;
	int lut_count;

	function new();
		cur_mode = MODE_MUL_FIRST;
		cur_scale = 128;
		cur_mask_en = 0;
		errors = 0;
		pixel_count = 0;
		lut_count = 0;
	endfunction

	function void set_reg(reg_idx_t idx, logic [15:0] val);
		case (idx)
			REG_MODE: cur_mode = mode_t'(val[1:0]);
			REG_MAX_SCALE: cur_scale = val;
			REG_MASK_ENABLE: cur_mask_en = val[0];
			default: ;
		endcase
	endfunction

	function automatic logic [7:0] lift(logic [7:0] base, int mag, logic [7:0] t);
		int inc;
		inc = (2 * mag * t + 255) / 510;
		return 8'((base + inc) & 255);
	endfunction

	// Table index that a pixel word reads under the current settings.
	function int slot_of(raw_t w);
		int diff;
		int sc;
		int slot;
		diff = cur_mode[0] ? int'(w.ref_pixel) - int'(w.in_pixel)
			: int'(w.in_pixel) - int'(w.ref_pixel);
		sc = (cur_scale == 0) ? 1 : cur_scale;
		slot = (256 * diff + sc) / (2 * sc) + 127;
		if (slot < 0) slot = 0;
		if (slot > 255) slot = 255;
		return slot;
	endfunction

	// A pixel word may be sent only if every entry it reads was loaded.
	function bit slot_ready(raw_t w);
		int slot;
		if (w.req_type || (cur_mask_en && w.mask_pixel == 8'd0))
			return 1;
		slot = slot_of(w);
		return lut_written[slot] && lut_written[256 + slot] && lut_written[512 + slot];
	endfunction

	// Note an accepted input word; queue the color it must produce.
	function void note_input(raw_t w);
		bit last_sel;
		bit abs_sel;
		logic [7:0] base;
		int diff;
		int slot;
		int mag;
		int entry;
		rgb_t res;
		last_sel = cur_mode[0];
		abs_sel = cur_mode[1];
		if (w.req_type) begin
			if (w.table_channel != 2'd3) begin
				entry = w.table_channel * 256 + w.table_index;
				color_lut[entry] = w.table_value;
				lut_written[entry] = 1;
			end
			lut_count++;
			return;
		end
		pixel_count++;
		base = (!abs_sel && !last_sel) ? w.ref_pixel : w.in_pixel;
		res = '{base, base, base};
		if (!(cur_mask_en && w.mask_pixel == 8'd0)) begin
			diff = last_sel ? int'(w.ref_pixel) - int'(w.in_pixel)
				: int'(w.in_pixel) - int'(w.ref_pixel);
			slot = slot_of(w);
			if (abs_sel) begin
				if (color_lut[slot] != 0 || color_lut[256 + slot] != 0
						|| color_lut[512 + slot] != 0)
					res = '{color_lut[slot], color_lut[256 + slot], color_lut[512 + slot]};
			end else begin
				mag = diff < 0 ? -diff : diff;
				res.r = lift(base, mag, color_lut[slot]);
				res.g = lift(base, mag, color_lut[256 + slot]);
				res.b = lift(base, mag, color_lut[512 + slot]);
			end
		end
		expected_rgb.push_back(res);
	endfunction

	function void check(rgb_t got);
		rgb_t exp_rgb;
		if (expected_rgb.size() == 0) begin
			$error("unexpected output word r=%0d g=%0d b=%0d", got.r, got.g, got.b);
			errors++;
			return;
		end
		exp_rgb = expected_rgb.pop_front();
		if (got.r !== exp_rgb.r) begin
			$error("red_out expected %0d actual %0d", exp_rgb.r, got.r);
			errors++;
		end
		if (got.g !== exp_rgb.g) begin
			$error("green_out expected %0d actual %0d", exp_rgb.g, got.g);
			errors++;
		end
		if (got.b !== exp_rgb.b) begin
			$error("blue_out expected %0d actual %0d", exp_rgb.b, got.b);
			errors++;
		end
	endfunction
endclass

module difference_color_mapper_tb;
	localparam int CycleLimit = 400000;
	localparam int DrainCycles = 30;

	logic clk;
	logic arst_n;
	logic cfg_write;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic req_type;
	logic [7:0] in_pixel;
	logic [7:0] ref_pixel;
	logic [7:0] mask_pixel;
	logic [7:0] table_index;
	logic [1:0] table_channel;
	logic [7:0] table_value;
	logic out_valid;
	logic out_stall;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;

	dcm_scoreboard color_sb;
	int cycle_count = 0;
	bit hold_request;

	difference_color_mapper uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .in_pixel(in_pixel), .ref_pixel(ref_pixel),
		.mask_pixel(mask_pixel), .table_index(table_index),
		.table_channel(table_channel), .table_value(table_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.red_out(red_out), .green_out(green_out), .blue_out(blue_out)
	);

	initial clk = 0;
	always #5 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("difference_color_mapper test failed");
			$finish;
		end
	end

	// Receiver stall: random gaps, plus one long hold-off on request.
	initial begin
		int n;
		out_stall = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 0;
				out_stall <= 1;
				repeat (300) @(posedge clk);
				out_stall <= 0;
			end else begin
				n = pick_gap();
				if (n > 0) begin
					out_stall <= 1;
					repeat (n) @(posedge clk);
					out_stall <= 0;
				end
			end
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			color_sb.check('{red_out, green_out, blue_out});

	task automatic write_reg(reg_idx_t idx, logic [15:0] val);
		@(posedge clk);
		cfg_write <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		color_sb.set_reg(idx, val);
		@(posedge clk);
		cfg_write <= 0;
	endtask

	// Drop the input valid, then wait until every pixel word has come out.
	task automatic wait_idle();
		in_valid <= 0;
		while (color_sb.expected_rgb.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic apply_settings(mode_t m, logic [15:0] sc, logic me);
		wait_idle();
		write_reg(REG_MODE, 16'(m));
		write_reg(REG_MAX_SCALE, sc);
		write_reg(REG_MASK_ENABLE, 16'(me));
	endtask

	// Offer one word after a random gap; return once it is accepted.
	task automatic send_word(raw_t w);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		req_type <= w.req_type;
		in_pixel <= w.in_pixel;
		ref_pixel <= w.ref_pixel;
		mask_pixel <= w.mask_pixel;
		table_index <= w.table_index;
		table_channel <= w.table_channel;
		table_value <= w.table_value;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		color_sb.note_input(w);
	endtask

	function automatic raw_t noise_word();
		raw_t w;
		w = raw_t'($bits(raw_t)'({$urandom, $urandom}));
		return w;
	endfunction

	function automatic raw_t pixel_word(logic [7:0] ip, logic [7:0] rp, logic [7:0] mp);
		raw_t w;
		w = noise_word();
		w.req_type = 0;
		w.in_pixel = ip;
		w.ref_pixel = rp;
		w.mask_pixel = mp;
		return w;
	endfunction

	function automatic raw_t lut_word(logic [7:0] idx, logic [1:0] ch, logic [7:0] val);
		raw_t w;
		w = noise_word();
		w.req_type = 1;
		w.table_index = idx;
		w.table_channel = ch;
		w.table_value = val;
		return w;
	endfunction

	function automatic raw_t random_candidate();
		int r;
		logic [7:0] ip;
		logic [7:0] rp;
		r = $urandom_range(0, 99);
		if (r < 8)
			return lut_word(8'($urandom), 2'($urandom_range(0, 3)),
				$urandom_range(0, 3) == 0 ? 8'd0 : 8'($urandom));
		ip = 8'($urandom);
		rp = 8'($urandom);
		if (r < 20) rp = ip;
		else if (r < 28) begin
			ip = $urandom_range(0, 1) ? 8'd255 : 8'd0;
			rp = ~ip;
		end
		return pixel_word(ip, rp, $urandom_range(0, 3) == 0 ? 8'd0 : 8'($urandom));
	endfunction

	// Retry up to 20 times for a word that reads only loaded entries; a zero difference hits the center.
	function automatic raw_t random_word();
		raw_t w;
		w = random_candidate();
		for (int tries = 0; tries < 20 && !color_sb.slot_ready(w); tries++)
			w = random_candidate();
		if (!color_sb.slot_ready(w))
			w.ref_pixel = w.in_pixel;
		return w;
	endfunction

	initial begin
		logic [15:0] scales [4];
		logic [7:0] lut_val;
		color_sb = new();
		hold_request = 0;
		cfg_write = 0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 0;
		req_type = 0;
		in_pixel = '0;
		ref_pixel = '0;
		mask_pixel = '0;
		table_index = '0;
		table_channel = '0;
		table_value = '0;
		arst_n = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// Load both ends and the middle of the table; leave the center entry black.
		for (int c = 0; c < 3; c++)
			for (int i = 0; i < 256; i++) begin
				if (i < 16 || (i >= 112 && i < 144) || i >= 240) begin
					lut_val = (i == 127 || $urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom);
					send_word(lut_word(8'(i), 2'(c), lut_val));
				end
			end
		send_word(lut_word(8'd5, 2'd3, 8'hFF));

		// Directed: extremes and masking in every mode.
		for (int m = 0; m < 4; m++) begin
			apply_settings(mode_t'(m), m == 1 ? 16'd1 : (m == 2 ? 16'hFFFF : 16'd128), 1'b1);
			send_word(pixel_word(8'd0, 8'd255, 8'd1));
			send_word(pixel_word(8'd255, 8'd0, 8'd255));
			send_word(pixel_word(8'd0, 8'd0, 8'd7));
			send_word(pixel_word(8'd255, 8'd255, 8'd128));
			send_word(pixel_word(8'd128, 8'd127, 8'd3));
			send_word(pixel_word(8'd200, 8'd10, 8'd0));
		end

		scales = '{16'd128, 16'd1, 16'hFFFF, 16'd0};
		for (int ph = 0; ph < 8; ph++) begin
			scales[3] = 16'($urandom_range(2, 2000));
			apply_settings(mode_t'(ph % 4), scales[ph / 2 % 4], ph % 3 != 0);
			if (ph == 3) hold_request = 1;
			for (int k = 0; k < 54; k++)
				send_word(random_word());
		end
		in_valid <= 0;

		wait_idle();
		$display("covered %0d pixel words and %0d table writes in all four modes",
			color_sb.pixel_count, color_sb.lut_count);
		if (color_sb.errors == 0)
			$display("difference_color_mapper test passed");
		else
			$display("difference_color_mapper test failed");
		$finish;
	end
endmodule
